/* hw/rtl/pid_speed_controller_unit_defines.svh */
// Assertion macros shared by the speed controller RTL.
`ifndef PID_SPEED_CONTROLLER_UNIT_DEFINES_SVH
`define PID_SPEED_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define PSC_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset.
`define PSC_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/psc_pkg.sv */
// Types and constants of the PID speed controller.
package psc_pkg;

    localparam int GAIN_W    = 16;
    localparam int IN_W      = 16;
    localparam int TIME_W    = 32;
    localparam int ERR_W     = 17;
    localparam int DERR_W    = 18;
    localparam int DK_W      = 28;   // error difference times 1000
    localparam int DER_W     = 29;   // derivative, per second
    localparam int INTEG_W   = 48;
    localparam int INTEG_SUM_W = 50;
    localparam int MC_W      = 48;   // multiplicand, signed
    localparam int MP_W      = 32;   // multiplier, unsigned, one bit per cycle
    localparam int PHI_W     = 49;   // upper product half
    localparam int PROD_W    = 64;
    localparam int DIV_W     = 64;   // dividend / quotient shift register
    localparam int REM_W     = 32;
    localparam int SUM_W     = 57;
    localparam int OUT_W     = 16;
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MP_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_W - 1);

    localparam logic [REM_W-1:0] MS_PER_SECOND = REM_W'(1000);

    localparam logic [GAIN_W-1:0] P_GAIN_RST = GAIN_W'(256);
    localparam logic [GAIN_W-1:0] I_GAIN_RST = GAIN_W'(128);
    localparam logic [GAIN_W-1:0] D_GAIN_RST = GAIN_W'(3);

    localparam logic [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    localparam logic [OUT_W-1:0] DRIVE_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] DRIVE_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_P_GAIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_I_GAIN = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_D_GAIN = CFG_IDX_W'(2);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_MUL_E  = 14'b00000000000010,  // error * dt
        S_INTEG  = 14'b00000000000100,
        S_MUL_I  = 14'b00000000001000,  // i_gain * integral
        S_DSET_I = 14'b00000000010000,
        S_DIV_I  = 14'b00000000100000,  // / 1000
        S_DSET_D = 14'b00000001000000,
        S_DIV_D  = 14'b00000010000000,  // error diff * 1000 / dt
        S_MSET_P = 14'b00000100000000,
        S_MUL_P  = 14'b00001000000000,  // p_gain * error
        S_MSET_D = 14'b00010000000000,
        S_MUL_D  = 14'b00100000000000,  // d_gain * derivative
        S_SUM    = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } t_state;

endpackage

/* hw/rtl/pid_speed_controller_unit.sv */
// PID speed controller with a bit-serial multiplier and divider.
//
//  channel | handshake                   | words
//  --------+-----------------------------+-------------------------------------
//  in      | i_in_valid / o_in_stall     | i_target, i_measured, i_time_ms
//  out     | o_out_valid / i_out_stall   | o_drive, o_clipped, o_zero_interval
//  cfg     | i_cfg_we                    | i_cfg_index, i_cfg_data
//
// One word runs from accept to result through four passes of the
// radix-2 multiplier, two of the restoring divider and seven further
// steps. The sequencer is back in idle as the result loads and takes no
// new word before then. A new input word is taken while the previous
// result still waits in the output register; a stalled output holds the
// sequencer in its last state. Reset (synchronous, active low) clears
// the gains to defaults, the stored time, error and integral, and the
// sequencer.
`include "pid_speed_controller_unit_defines.svh"

module pid_speed_controller_unit #(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [psc_pkg::GAIN_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [psc_pkg::IN_W-1:0]      i_target,
    input  logic [psc_pkg::IN_W-1:0]      i_measured,
    input  logic [psc_pkg::TIME_W-1:0]    i_time_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [psc_pkg::OUT_W-1:0]     o_drive,
    output logic                          o_clipped,
    output logic                          o_zero_interval
);
    import psc_pkg::*;

    localparam int SHR_W = SUM_W - GAIN_FRAC_BITS;

    // control and architectural state
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [GAIN_W-1:0]   r_p_gain, n_p_gain;
    logic [GAIN_W-1:0]   r_i_gain, n_i_gain;
    logic [GAIN_W-1:0]   r_d_gain, n_d_gain;
    logic [TIME_W-1:0]   r_last_time, n_last_time;
    logic [INTEG_W-1:0]  r_integ, n_integ;
    logic [ERR_W-1:0]    r_last_err, n_last_err;
    logic                r_out_valid, n_out_valid;

    // datapath
    logic [TIME_W-1:0]   r_dt, n_dt;
    logic [ERR_W-1:0]    r_err, n_err;
    logic [DERR_W-1:0]   r_derr, n_derr;
    logic                r_zero, n_zero;
    logic [DER_W-1:0]    r_deriv, n_deriv;
    logic [SUM_W-1:0]    r_acc, n_acc;
    logic [MC_W-1:0]     r_mcand, n_mcand;
    logic [MP_W-1:0]     r_mplr, n_mplr;
    logic [PHI_W-1:0]    r_phi, n_phi;
    logic [DIV_W-1:0]    r_dq, n_dq;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [REM_W-1:0]    r_dvs, n_dvs;
    logic                r_neg, n_neg;
    logic [OUT_W-1:0]    r_drive, n_drive;
    logic                r_clipped, n_clipped;
    logic                r_zero_out, n_zero_out;

    // shared combinational pieces
    logic [PHI_W-1:0]       mul_add;
    logic [PROD_W-1:0]      prod;
    logic [REM_W:0]         div_shift;
    logic [REM_W+1:0]       div_sub;
    logic                   div_ge;
    logic [DIV_W-1:0]       quot;
    logic [ERR_W-1:0]       in_err;
    logic [TIME_W-1:0]      in_dt;
    logic [INTEG_SUM_W-1:0] integ_sum;
    logic [INTEG_W-1:0]     integ_sat;
    logic [DK_W-1:0]        dk_x;
    logic [DK_W-1:0]        dk;
    logic [DK_W-1:0]        dk_mag;
    logic [SHR_W-1:0]       shr;
    logic [SHR_W-OUT_W:0]   shr_top;
    logic                   clip;
    logic                   in_acc;
    logic                   out_free;

    assign o_in_stall      = (r_state != S_IDLE);
    assign in_acc          = i_in_valid && !o_in_stall;
    assign out_free        = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_drive         = r_drive;
    assign o_clipped       = r_clipped;
    assign o_zero_interval = r_zero_out;

    // multiplier: add on multiplier LSB, then shift the pair right
    assign mul_add = r_phi + (r_mplr[0] ? {r_mcand[MC_W-1], r_mcand} : '0);
    assign prod    = {r_phi[PROD_W-MP_W-1:0], r_mplr};

    // divider: one restoring step per cycle
    assign div_shift = {r_rem, r_dq[DIV_W-1]};
    assign div_sub   = {1'b0, div_shift} - {2'b00, r_dvs};
    assign div_ge    = !div_sub[REM_W+1];
    assign quot      = r_neg ? (~r_dq + DIV_W'(1)) : r_dq;

    assign in_err = {i_target[IN_W-1], i_target} - {i_measured[IN_W-1], i_measured};
    assign in_dt  = i_time_ms - r_last_time;

    assign integ_sum = {{(INTEG_SUM_W-INTEG_W){r_integ[INTEG_W-1]}}, r_integ}
                     + prod[INTEG_SUM_W-1:0];
    always_comb begin
        if (!integ_sum[INTEG_SUM_W-1] && (integ_sum[INTEG_SUM_W-2:INTEG_W-1] != '0)) begin
            integ_sat = INTEG_MAX;
        end else if (integ_sum[INTEG_SUM_W-1]
                     && (integ_sum[INTEG_SUM_W-2:INTEG_W-1] != '1)) begin
            integ_sat = INTEG_MIN;
        end else begin
            integ_sat = integ_sum[INTEG_W-1:0];
        end
    end

    // x*1000 = x*1024 - x*16 - x*8
    assign dk_x   = {{(DK_W-DERR_W){r_derr[DERR_W-1]}}, r_derr};
    assign dk     = (dk_x << 10) - (dk_x << 4) - (dk_x << 3);
    assign dk_mag = dk[DK_W-1] ? (~dk + DK_W'(1)) : dk;

    // arithmetic shift right is the floor; clip when the top bits disagree
    assign shr     = r_acc[SUM_W-1:GAIN_FRAC_BITS];
    assign shr_top = shr[SHR_W-1:OUT_W-1];
    assign clip    = !((&shr_top) || !(|shr_top));

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_p_gain    = r_p_gain;
        n_i_gain    = r_i_gain;
        n_d_gain    = r_d_gain;
        n_last_time = r_last_time;
        n_integ     = r_integ;
        n_last_err  = r_last_err;
        n_out_valid = r_out_valid && i_out_stall;
        n_dt        = r_dt;
        n_err       = r_err;
        n_derr      = r_derr;
        n_zero      = r_zero;
        n_deriv     = r_deriv;
        n_acc       = r_acc;
        n_mcand     = r_mcand;
        n_mplr      = r_mplr;
        n_phi       = r_phi;
        n_dq        = r_dq;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_neg       = r_neg;
        n_drive     = r_drive;
        n_clipped   = r_clipped;
        n_zero_out  = r_zero_out;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_P_GAIN: n_p_gain = i_cfg_data;
                REG_I_GAIN: n_i_gain = i_cfg_data;
                REG_D_GAIN: n_d_gain = i_cfg_data;
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_last_time = i_time_ms;
                    n_dt        = in_dt;
                    n_err       = in_err;
                    n_zero      = (in_dt == '0);
                    n_mcand     = {{(MC_W-ERR_W){in_err[ERR_W-1]}}, in_err};
                    n_mplr      = in_dt;
                    n_phi       = '0;
                    n_cnt       = '0;
                    n_state     = S_MUL_E;
                end
            end
            S_MUL_E, S_MUL_I, S_MUL_P, S_MUL_D: begin
                n_phi  = {mul_add[PHI_W-1], mul_add[PHI_W-1:1]};
                n_mplr = {mul_add[0], r_mplr[MP_W-1:1]};
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == MUL_LAST) begin
                    unique case (r_state)
                        S_MUL_E: n_state = S_INTEG;
                        S_MUL_I: n_state = S_DSET_I;
                        S_MUL_P: n_state = S_MSET_D;
                        default: n_state = S_SUM;
                    endcase
                end
            end
            S_INTEG: begin
                n_integ    = integ_sat;
                n_derr     = {r_err[ERR_W-1], r_err} - {r_last_err[ERR_W-1], r_last_err};
                n_last_err = r_err;
                n_mcand    = integ_sat;
                n_mplr     = {{(MP_W-GAIN_W){1'b0}}, r_i_gain};
                n_phi      = '0;
                n_cnt      = '0;
                n_state    = S_MUL_I;
            end
            S_DSET_I: begin
                n_neg   = prod[PROD_W-1];
                n_dq    = prod[PROD_W-1] ? (~prod + PROD_W'(1)) : prod;
                n_rem   = '0;
                n_dvs   = MS_PER_SECOND;
                n_cnt   = '0;
                n_state = S_DIV_I;
            end
            S_DIV_I, S_DIV_D: begin
                n_rem = div_ge ? div_sub[REM_W-1:0] : div_shift[REM_W-1:0];
                n_dq  = {r_dq[DIV_W-2:0], div_ge};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == DIV_LAST) begin
                    n_state = (r_state == S_DIV_I) ? S_DSET_D : S_MSET_P;
                end
            end
            S_DSET_D: begin
                n_acc   = quot[SUM_W-1:0];
                n_neg   = dk[DK_W-1];
                n_dq    = {{(DIV_W-DK_W){1'b0}}, dk_mag};
                n_rem   = '0;
                n_dvs   = r_dt;
                n_cnt   = '0;
                n_state = S_DIV_D;
            end
            S_MSET_P: begin
                // zero interval: the divider ran on a zero divisor, drop it
                n_deriv = r_zero ? '0 : quot[DER_W-1:0];
                n_mcand = {{(MC_W-ERR_W){r_err[ERR_W-1]}}, r_err};
                n_mplr  = {{(MP_W-GAIN_W){1'b0}}, r_p_gain};
                n_phi   = '0;
                n_cnt   = '0;
                n_state = S_MUL_P;
            end
            S_MSET_D: begin
                n_acc   = r_acc + prod[SUM_W-1:0];
                n_mcand = {{(MC_W-DER_W){r_deriv[DER_W-1]}}, r_deriv};
                n_mplr  = {{(MP_W-GAIN_W){1'b0}}, r_d_gain};
                n_phi   = '0;
                n_cnt   = '0;
                n_state = S_MUL_D;
            end
            S_SUM: begin
                n_acc   = r_acc + prod[SUM_W-1:0];
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_drive     = clip ? (shr[SHR_W-1] ? DRIVE_MIN : DRIVE_MAX)
                                       : shr[OUT_W-1:0];
                    n_clipped   = clip;
                    n_zero_out  = r_zero;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_p_gain    <= P_GAIN_RST;
            r_i_gain    <= I_GAIN_RST;
            r_d_gain    <= D_GAIN_RST;
            r_last_time <= '0;
            r_integ     <= '0;
            r_last_err  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_p_gain    <= n_p_gain;
            r_i_gain    <= n_i_gain;
            r_d_gain    <= n_d_gain;
            r_last_time <= n_last_time;
            r_integ     <= n_integ;
            r_last_err  <= n_last_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dt       <= n_dt;
        r_err      <= n_err;
        r_derr     <= n_derr;
        r_zero     <= n_zero;
        r_deriv    <= n_deriv;
        r_acc      <= n_acc;
        r_mcand    <= n_mcand;
        r_mplr     <= n_mplr;
        r_phi      <= n_phi;
        r_dq       <= n_dq;
        r_rem      <= n_rem;
        r_dvs      <= n_dvs;
        r_neg      <= n_neg;
        r_drive    <= n_drive;
        r_clipped  <= n_clipped;
        r_zero_out <= n_zero_out;
    end

    `PSC_ASSERT_NXT(a_accept_starts, in_acc, r_state == S_MUL_E,
                    "accepted word did not start")
    `PSC_ASSERT_IMP(a_rem_below_dvs,
                    (r_state == S_DIV_I || r_state == S_DIV_D) && (r_dvs != '0),
                    r_rem < r_dvs, "divider remainder out of range")
    `PSC_ASSERT_NXT(a_zero_deriv, r_state == S_MSET_P && r_zero, r_deriv == '0,
                    "derivative not zero on zero interval")
    `PSC_ASSERT_IMP(a_valid_from_out, $rose(r_out_valid), $past(r_state == S_OUT),
                    "result word outside output state")

endmodule

/* tb/sv/pid_speed_controller_unit_checker.sv */
// Checker for the speed controller: predicts each drive word and compares it.
module pid_speed_controller_unit_checker #(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [psc_pkg::GAIN_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [psc_pkg::IN_W-1:0]      i_target,
    input  logic [psc_pkg::IN_W-1:0]      i_measured,
    input  logic [psc_pkg::TIME_W-1:0]    i_time_ms,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [psc_pkg::OUT_W-1:0]     i_drive,
    input  logic                          i_clipped,
    input  logic                          i_zero_interval,
    output int                            o_fail_count,
    output int                            o_pending
);
    import psc_pkg::*;

    localparam longint MS_PER_S = 1000;
    localparam longint INTEG_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint INTEG_LO = -INTEG_HI - 1;
    localparam longint DRIVE_HI = 32767;
    localparam longint DRIVE_LO = -32768;

    typedef struct packed {
        logic [OUT_W-1:0] drive;
        logic             clipped;
        logic             zero_interval;
    } t_drive_word;

    logic [GAIN_W-1:0] p_gain_m = P_GAIN_RST;
    logic [GAIN_W-1:0] i_gain_m = I_GAIN_RST;
    logic [GAIN_W-1:0] d_gain_m = D_GAIN_RST;
    logic [TIME_W-1:0] prev_time = '0;
    longint            integ_acc = 0;
    longint            prev_err = 0;
    t_drive_word       drive_q[$];
    t_drive_word       want;
    int                fail_count = 0;

    task automatic report_mismatch(input string what, input longint got,
                                   input longint exp_v);
        $display("mismatch at %0t: %s got %0d, want %0d", $time, what, got, exp_v);
        fail_count++;
    endtask

    // One controller step: updates the integral, error and time state.
    function automatic t_drive_word predict_drive(input logic [IN_W-1:0] tgt,
                                                  input logic [IN_W-1:0] meas,
                                                  input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] dt;
        longint            dt_l;
        longint            err;
        longint            deriv;
        longint            iterm;
        longint            total;
        longint            shifted;
        t_drive_word       w;
        dt = now - prev_time;
        dt_l = longint'({32'b0, dt});
        err = longint'($signed(tgt)) - longint'($signed(meas));
        integ_acc = integ_acc + err * dt_l;
        if (integ_acc > INTEG_HI)
            integ_acc = INTEG_HI;
        else if (integ_acc < INTEG_LO)
            integ_acc = INTEG_LO;
        deriv = (dt == '0) ? 0 : ((err - prev_err) * MS_PER_S) / dt_l;
        iterm = (longint'({48'b0, i_gain_m}) * integ_acc) / MS_PER_S;
        total = longint'({48'b0, p_gain_m}) * err + iterm
              + longint'({48'b0, d_gain_m}) * deriv;
        // arithmetic shift floors toward minus infinity
        shifted = total >>> GAIN_FRAC_BITS;
        w.zero_interval = (dt == '0);
        w.clipped = 1'b0;
        if (shifted > DRIVE_HI) begin
            w.drive = DRIVE_MAX;
            w.clipped = 1'b1;
        end else if (shifted < DRIVE_LO) begin
            w.drive = DRIVE_MIN;
            w.clipped = 1'b1;
        end else begin
            w.drive = shifted[OUT_W-1:0];
        end
        prev_err = err;
        prev_time = now;
        return w;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            p_gain_m = P_GAIN_RST;
            i_gain_m = I_GAIN_RST;
            d_gain_m = D_GAIN_RST;
            prev_time = '0;
            integ_acc = 0;
            prev_err = 0;
            drive_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_P_GAIN: p_gain_m = i_cfg_data;
                    REG_I_GAIN: i_gain_m = i_cfg_data;
                    REG_D_GAIN: d_gain_m = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                drive_q.push_back(predict_drive(i_target, i_measured, i_time_ms));
            if (i_out_valid && !i_out_stall) begin
                if (drive_q.size() == 0) begin
                    report_mismatch("drive word with none pending",
                                    longint'($signed(i_drive)), 0);
                end else begin
                    want = drive_q.pop_front();
                    if (i_drive !== want.drive)
                        report_mismatch("drive", longint'($signed(i_drive)),
                                        longint'($signed(want.drive)));
                    if (i_clipped !== want.clipped)
                        report_mismatch("clipped", longint'(i_clipped), longint'(want.clipped));
                    if (i_zero_interval !== want.zero_interval)
                        report_mismatch("zero_interval", longint'(i_zero_interval),
                                        longint'(want.zero_interval));
                end
            end
        end
        o_pending <= drive_q.size();
        o_fail_count <= fail_count;
    end

endmodule

/* tb/sv/pid_speed_controller_unit_tb.sv */
// Testbench top for the speed controller: clock, reset, stimulus and verdict.
module pid_speed_controller_unit_tb;
    import psc_pkg::*;

    localparam int FRAC_BITS = 8;
    localparam int IDLE_LIMIT = 4000;
    localparam int N_PHASES = 8;
    localparam int WORDS_PER_PHASE = 160;
    localparam int DRAIN_CYCLES = 300;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

    logic                 i_clk = 1'b0;
    logic                 r_rst_n = 1'b0;
    logic                 r_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] r_cfg_index = '0;
    logic [GAIN_W-1:0]    r_cfg_data = '0;
    logic                 r_in_valid = 1'b0;
    logic [IN_W-1:0]      r_target = '0;
    logic [IN_W-1:0]      r_measured = '0;
    logic [TIME_W-1:0]    r_time_ms = '0;
    logic                 r_out_stall = 1'b0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [OUT_W-1:0]     o_drive;
    logic                 o_clipped;
    logic                 o_zero_interval;

    int                   fail_count;
    int                   pending;
    logic [TIME_W-1:0]    now_ms = '0;
    bit                   quiet = 1'b0;

    wire word_moved = (r_in_valid && !o_in_stall) || (o_out_valid && !r_out_stall) || r_cfg_we;

    pid_speed_controller_unit #(
        .GAIN_FRAC_BITS(FRAC_BITS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (r_rst_n),
        .i_cfg_we       (r_cfg_we),
        .i_cfg_index    (r_cfg_index),
        .i_cfg_data     (r_cfg_data),
        .i_in_valid     (r_in_valid),
        .o_in_stall     (o_in_stall),
        .i_target       (r_target),
        .i_measured     (r_measured),
        .i_time_ms      (r_time_ms),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (r_out_stall),
        .o_drive        (o_drive),
        .o_clipped      (o_clipped),
        .o_zero_interval(o_zero_interval)
    );

    pid_speed_controller_unit_checker #(
        .GAIN_FRAC_BITS(FRAC_BITS)
    ) chk (
        .i_clk          (i_clk),
        .i_rst_n        (r_rst_n),
        .i_cfg_we       (r_cfg_we),
        .i_cfg_index    (r_cfg_index),
        .i_cfg_data     (r_cfg_data),
        .i_in_valid     (r_in_valid),
        .i_in_stall     (o_in_stall),
        .i_target       (r_target),
        .i_measured     (r_measured),
        .i_time_ms      (r_time_ms),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (r_out_stall),
        .i_drive        (o_drive),
        .i_clipped      (o_clipped),
        .i_zero_interval(o_zero_interval),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    initial begin
        int n;
        forever begin
            n = quiet ? 0 : gap_len();
            if (n > 0) begin
                r_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                r_out_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (word_moved)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send_word(input logic [IN_W-1:0] tgt, input logic [IN_W-1:0] meas,
                             input logic [TIME_W-1:0] tm);
        int n;
        n = quiet ? 0 : gap_len();
        if (n > 0) begin
            r_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        r_target <= tgt;
        r_measured <= meas;
        r_time_ms <= tm;
        r_in_valid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!(r_in_valid && !o_in_stall));
    endtask

    task automatic send_random_word();
        int                mode;
        logic [IN_W-1:0]   tgt;
        logic [IN_W-1:0]   meas;
        logic [TIME_W-1:0] step;
        mode = $urandom_range(0, 99);
        tgt = IN_W'($urandom);
        meas = IN_W'($urandom);
        if (mode < 55) begin
            // regular tick, feedback often close to the setpoint
            step = $urandom_range(1, 50);
            if ($urandom_range(0, 1))
                meas = tgt ^ IN_W'($urandom_range(0, 255));
        end else if (mode < 65) begin
            step = '0;
        end else if (mode < 75) begin
            step = $urandom_range(51, 100000);
        end else if (mode < 83) begin
            step = $urandom;
        end else if (mode < 90) begin
            step = $urandom_range(0, 3);
            tgt = $urandom_range(0, 1) ? DRIVE_MAX : DRIVE_MIN;
            meas = $urandom_range(0, 1) ? DRIVE_MAX : DRIVE_MIN;
        end else begin
            // full error in either direction over a short tick
            step = $urandom_range(1, 5);
            tgt = DRIVE_MAX;
            meas = DRIVE_MIN;
            if ($urandom_range(0, 1)) begin
                tgt = DRIVE_MIN;
                meas = DRIVE_MAX;
            end
        end
        now_ms = now_ms + step;
        send_word(tgt, meas, now_ms);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        r_cfg_we <= 1'b1;
        r_cfg_index <= idx;
        r_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic drain();
        r_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        r_rst_n <= 1'b1;
        @(posedge i_clk);

        // default gains; first word measures dt from zero
        send_word(16'sd100, 16'sd0, 32'd5);
        send_word(16'sd200, 16'sd50, 32'd5);
        send_word(DRIVE_MAX, DRIVE_MIN, 32'd6);
        send_word(DRIVE_MIN, DRIVE_MAX, 32'd7);
        // dt of all ones: integral hits its upper limit, then its lower one
        send_word(DRIVE_MAX, DRIVE_MIN, 32'd6);
        send_word(DRIVE_MAX, DRIVE_MIN, 32'd5);
        send_word(DRIVE_MIN, DRIVE_MAX, 32'd4);
        send_word(DRIVE_MIN, DRIVE_MAX, 32'd3);
        send_word(16'sd0, 16'sd0, 32'hFFFF_FFF0);
        send_word(16'sd0, 16'sd0, 32'hFFFF_FFF0);
        send_word(16'h1234, 16'h1200, 32'h0000_0010);
        send_word(16'sd0, 16'sd0, 32'h0000_0011);
        send_word(16'hFFFF, 16'h0001, 32'h0000_0012);
        send_word(DRIVE_MIN, DRIVE_MIN, 32'h0000_0013);
        send_word(DRIVE_MAX, DRIVE_MAX, 32'h0000_0014);
        now_ms = 32'h0000_0014;

        for (int phase = 0; phase < N_PHASES; phase++) begin
            if (phase > 0) begin
                drain();
                case (phase)
                    1: begin
                        write_reg(REG_P_GAIN, '1);
                        write_reg(REG_I_GAIN, '1);
                        write_reg(REG_D_GAIN, '1);
                    end
                    2: begin
                        write_reg(REG_P_GAIN, '0);
                        write_reg(REG_I_GAIN, '0);
                        write_reg(REG_D_GAIN, '0);
                    end
                    3: begin
                        write_reg(REG_P_GAIN, '1);
                        write_reg(REG_UNUSED, GAIN_W'($urandom));
                    end
                    4: begin
                        write_reg(REG_P_GAIN, '0);
                        write_reg(REG_I_GAIN, '1);
                    end
                    5: begin
                        write_reg(REG_I_GAIN, '0);
                        write_reg(REG_D_GAIN, '1);
                    end
                    6: begin
                        write_reg(REG_P_GAIN, GAIN_W'($urandom));
                        write_reg(REG_I_GAIN, GAIN_W'($urandom));
                        write_reg(REG_D_GAIN, GAIN_W'($urandom));
                        write_reg(REG_UNUSED, GAIN_W'($urandom));
                    end
                    default: begin
                        write_reg(REG_P_GAIN, GAIN_W'($urandom_range(0, 1023)));
                        write_reg(REG_I_GAIN, GAIN_W'($urandom_range(0, 1023)));
                        write_reg(REG_D_GAIN, GAIN_W'($urandom_range(0, 63)));
                    end
                endcase
                r_cfg_we <= 1'b0;
            end
            quiet = (phase == 3) || ($urandom_range(0, 3) == 0);
            for (int k = 0; k < WORDS_PER_PHASE; k++)
                send_random_word();
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/psc_pkg.sv
hw/rtl/pid_speed_controller_unit.sv
tb/sv/pid_speed_controller_unit_checker.sv
tb/sv/pid_speed_controller_unit_tb.sv
